// ===== hw/rtl/mbet_pkg.sv =====
// Package: shared types and constants of the escape-time pixel block.
`timescale 1ns / 1ps

package mbet_pkg;

  localparam int unsigned IN_BITS   = 28;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned ITER_BITS = 12;
  localparam int unsigned ZW        = FRAC_BITS + 8;  // Q7.F working values
  localparam int unsigned MW        = FRAC_BITS + 3;  // magnitude below 5.0

  localparam logic [ITER_BITS-1:0] LIMIT_RESET = ITER_BITS'(10);

  // colour numerators: red = (306 i + 50) / 100, green/blue = (k i + 5) / 10
  localparam int unsigned RED_NW = 15;
  localparam int unsigned GB_NW  = 12;
  localparam int unsigned RW     = 13;

  localparam logic [RED_NW-1:0] RED_STEP = RED_NW'(306);
  localparam logic [RED_NW-1:0] RED_BIAS = RED_NW'(50);
  localparam logic [GB_NW-1:0]  GRN_STEP = GB_NW'(102);
  localparam logic [GB_NW-1:0]  BLU_STEP = GB_NW'(204);
  localparam logic [GB_NW-1:0]  GB_BIAS  = GB_NW'(5);

  localparam logic [RW-1:0] RED_RECIP = RW'(5243);  // 2^19 / 100
  localparam int unsigned   RED_SHIFT = 19;
  localparam logic [RW-1:0] GB_RECIP  = RW'(6554);  // 2^16 / 10
  localparam int unsigned   GB_SHIFT  = 16;

  localparam logic [ITER_BITS-1:0] RED_SAT_IDX = ITER_BITS'(84);
  localparam logic [ITER_BITS-1:0] GRN_SAT_IDX = ITER_BITS'(26);
  localparam logic [ITER_BITS-1:0] BLU_SAT_IDX = ITER_BITS'(13);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_XY,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic signed [IN_BITS-1:0] point_real;
    logic signed [IN_BITS-1:0] point_imag;
  } pixel_in_t;

  typedef struct packed {
    logic                 escaped;
    logic [ITER_BITS-1:0] escape_index;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
  } pixel_out_t;

  typedef struct packed {
    logic clear;
    logic step;
  } shade_ctrl_t;

endpackage

// ===== hw/rtl/mbet_shade.sv =====
// Colour map: running numerators per iteration and reciprocal scaling to 8-bit RGB.
`timescale 1ns / 1ps

module mbet_shade (
  input  logic                           clk_i,
  input  mbet_pkg::shade_ctrl_t          ctrl_i,
  input  logic [mbet_pkg::ITER_BITS-1:0] index_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o
);

  logic [mbet_pkg::RED_NW-1:0] nr_q, nr_d;
  logic [mbet_pkg::GB_NW-1:0]  ng_q, ng_d;
  logic [mbet_pkg::GB_NW-1:0]  nb_q, nb_d;

  logic [mbet_pkg::RED_NW+mbet_pkg::RW-1:0] red_prod;
  logic [mbet_pkg::GB_NW+mbet_pkg::RW-1:0]  grn_prod;
  logic [mbet_pkg::GB_NW+mbet_pkg::RW-1:0]  blu_prod;

  always_comb begin
    nr_d = nr_q;
    ng_d = ng_q;
    nb_d = nb_q;
    if (ctrl_i.clear) begin
      nr_d = mbet_pkg::RED_BIAS;
      ng_d = mbet_pkg::GB_BIAS;
      nb_d = mbet_pkg::GB_BIAS;
    end else if (ctrl_i.step) begin
      nr_d = nr_q + mbet_pkg::RED_STEP;
      ng_d = ng_q + mbet_pkg::GRN_STEP;
      nb_d = nb_q + mbet_pkg::BLU_STEP;
    end
  end

  always_ff @(posedge clk_i) begin
    nr_q <= nr_d;
    ng_q <= ng_d;
    nb_q <= nb_d;
  end

  // numerators wrap only past the saturation index, where they are unused
  assign red_prod = {{mbet_pkg::RW{1'b0}}, nr_q} *
                    {{mbet_pkg::RED_NW{1'b0}}, mbet_pkg::RED_RECIP};
  assign grn_prod = {{mbet_pkg::RW{1'b0}}, ng_q} *
                    {{mbet_pkg::GB_NW{1'b0}}, mbet_pkg::GB_RECIP};
  assign blu_prod = {{mbet_pkg::RW{1'b0}}, nb_q} *
                    {{mbet_pkg::GB_NW{1'b0}}, mbet_pkg::GB_RECIP};

  assign red_o   = (index_i >= mbet_pkg::RED_SAT_IDX) ? 8'hFF :
                   red_prod[mbet_pkg::RED_SHIFT +: 8];
  assign green_o = (index_i >= mbet_pkg::GRN_SAT_IDX) ? 8'hFF :
                   grn_prod[mbet_pkg::GB_SHIFT +: 8];
  assign blue_o  = (index_i >= mbet_pkg::BLU_SAT_IDX) ? 8'hFF :
                   blu_prod[mbet_pkg::GB_SHIFT +: 8];

endmodule

// ===== hw/rtl/mandelbrot_escape_time_pixel.sv =====
// Top level: escape-time iteration of one point on a shared multiplier, with colour output.
//
//  channel   dir  signals                  transfer
//  pixel     in   start, busy, pixel_i     start high and busy low at clk_i edge
//  result    out  done_o, result_o         done_o high for one cycle, always taken
//  config    in   cfg_we_i, cfg_wdata_i    cfg_we_i high at clk_i edge
//
//  One multiplier serves zx^2, zy^2 and zx*zy in turn: each iteration steps through SQX, SQY, XY, UPD.
//  A point runs k iterations before done_o, k being the escape index + 1, or the
//  limit; a limit of 0 gives done_o straight from the transfer, through done_q.
//  busy is high from the transfer until the cycle before done_o (never for a limit of 0).
//  rst_ni clears the sequencer and sets the limit to 10; no clearing pass.
//  The receiver cannot stall; results are never held back.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  mbet_pkg::pixel_in_t            pixel_i,
  output logic                           done_o,
  output mbet_pkg::pixel_out_t           result_o,
  input  logic                           cfg_we_i,
  input  logic [mbet_pkg::ITER_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned ZW = mbet_pkg::ZW;
  localparam int unsigned MW = mbet_pkg::MW;
  localparam int unsigned F  = mbet_pkg::FRAC_BITS;
  localparam int unsigned IB = mbet_pkg::IN_BITS;
  localparam logic signed [ZW-1:0] ESC_POS = ZW'(5) << F;
  localparam logic signed [ZW-1:0] ESC_NEG = -ESC_POS;

  mbet_pkg::state_e state_q, state_d;

  logic [mbet_pkg::ITER_BITS-1:0] iter_q, iter_d;
  logic [mbet_pkg::ITER_BITS-1:0] limit_q;
  logic                           done_q, done_d;
  mbet_pkg::pixel_out_t           res_q, res_d;

  logic signed [ZW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0] zx_q, zx_d, zy_q, zy_d;
  logic signed [ZW-1:0] xx_q, xx_d, tx_q, tx_d;
  logic [2*MW-1:0]      prod_q, prod_d;

  logic signed [ZW-1:0] zx_abs, zy_abs;
  logic [MW-1:0]        ax, ay, mul_a, mul_b;
  logic [2*MW-1:0]      prod;
  logic signed [ZW-1:0] sq_val, tym, ty, zx_n, zy_n;
  logic                 esc;

  mbet_pkg::shade_ctrl_t shade_ctrl;
  logic [7:0]            red, green, blue;

  mbet_shade u_shade (
    .clk_i   (clk_i),
    .ctrl_i  (shade_ctrl),
    .index_i (iter_q),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  assign zx_abs = zx_q[ZW-1] ? -zx_q : zx_q;
  assign zy_abs = zy_q[ZW-1] ? -zy_q : zy_q;
  assign ax     = zx_abs[MW-1:0];
  assign ay     = zy_abs[MW-1:0];

  always_comb begin
    case (state_q)
      mbet_pkg::ST_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      mbet_pkg::ST_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      default: begin
        mul_a = ax;
        mul_b = ay;
      end
    endcase
  end

  assign prod   = {{MW{1'b0}}, mul_a} * {{MW{1'b0}}, mul_b};
  assign sq_val = ZW'(prod_q >> F);
  assign tym    = ZW'(prod_q >> (F - 1));
  assign ty     = (zx_q[ZW-1] != zy_q[ZW-1]) ? -tym : tym;
  assign zx_n   = tx_q + cx_q;
  assign zy_n   = ty + cy_q;
  assign esc    = (zx_n >= ESC_POS) || (zx_n <= ESC_NEG) ||
                  (zy_n >= ESC_POS) || (zy_n <= ESC_NEG);

  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    done_d     = 1'b0;
    res_d      = res_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    zx_d       = zx_q;
    zy_d       = zy_q;
    xx_d       = xx_q;
    tx_d       = tx_q;
    prod_d     = prod_q;
    shade_ctrl = '0;
    case (state_q)
      mbet_pkg::ST_IDLE: begin
        if (start) begin
          cx_d = {{(ZW-IB-1){pixel_i.point_real[IB-1]}}, pixel_i.point_real, 1'b0};
          cy_d = {{(ZW-IB-1){pixel_i.point_imag[IB-1]}}, pixel_i.point_imag, 1'b0};
          zx_d = '0;
          zy_d = '0;
          iter_d = '0;
          shade_ctrl.clear = 1'b1;
          if (limit_q == '0) begin
            res_d  = '0;
            done_d = 1'b1;
          end else begin
            state_d = mbet_pkg::ST_SQX;
          end
        end
      end
      mbet_pkg::ST_SQX: begin
        prod_d  = prod;
        state_d = mbet_pkg::ST_SQY;
      end
      mbet_pkg::ST_SQY: begin
        xx_d    = sq_val;
        prod_d  = prod;
        state_d = mbet_pkg::ST_XY;
      end
      mbet_pkg::ST_XY: begin
        tx_d    = xx_q - sq_val;
        prod_d  = prod;
        state_d = mbet_pkg::ST_UPD;
      end
      mbet_pkg::ST_UPD: begin
        zx_d = zx_n;
        zy_d = zy_n;
        if (esc) begin
          res_d.escaped      = 1'b1;
          res_d.escape_index = iter_q;
          res_d.red          = red;
          res_d.green        = green;
          res_d.blue         = blue;
          done_d             = 1'b1;
          state_d            = mbet_pkg::ST_IDLE;
        end else if (iter_q == limit_q - 1'b1) begin
          res_d   = '0;
          done_d  = 1'b1;
          state_d = mbet_pkg::ST_IDLE;
        end else begin
          iter_d          = iter_q + 1'b1;
          shade_ctrl.step = 1'b1;
          state_d         = mbet_pkg::ST_SQX;
        end
      end
      default: begin
        state_d = mbet_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbet_pkg::ST_IDLE;
      iter_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mbet_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    zx_q   <= zx_d;
    zy_q   <= zy_d;
    xx_q   <= xx_d;
    tx_q   <= tx_d;
    prod_q <= prod_d;
  end

  assign busy     = (state_q != mbet_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(state_q == mbet_pkg::ST_UPD) || $past(start && !busy))
    else $error("result strobe without a finished point");

  a_index_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.escaped |-> result_o.escape_index < limit_q)
    else $error("escape index not below limit");

  a_black_when_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.escaped |->
      result_o.escape_index == '0 && result_o.red == '0 &&
      result_o.green == '0 && result_o.blue == '0)
    else $error("non-escaped point not black");

  a_iter_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> iter_q < limit_q)
    else $error("iteration counter past limit");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy || $past(!busy))
    else $error("result strobe while a point is still in flight");

endmodule

// ===== tb/mbet_checker.sv =====
// Checker: predicts escape-time results and compares them with the block's output.
`timescale 1ns / 1ps

module mbet_checker
  import mbet_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  pixel_in_t            pixel_i,
  input  logic                 done_i,
  input  pixel_out_t           result_i,
  input  logic                 cfg_we_i,
  input  logic [ITER_BITS-1:0] cfg_wdata_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam logic [ITER_BITS-1:0] DEFAULT_LIMIT = ITER_BITS'(10);

  logic [ITER_BITS-1:0] iter_limit;
  pixel_out_t           colour_q[$];

  // round(idx * num / den), halves up, saturated at 255
  function automatic logic [7:0] shade(int unsigned idx, int unsigned num, int unsigned den);
    int unsigned v;
    v = (2 * idx * num + den) / (2 * den);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pixel_out_t escape_predict(pixel_in_t p, logic [ITER_BITS-1:0] lim);
    longint            cx, cy, zx, zy, tx, ty;
    longint unsigned   ax, ay, tym, bound;
    pixel_out_t        r;
    r     = '0;
    cx    = 2 * longint'(p.point_real);
    cy    = 2 * longint'(p.point_imag);
    zx    = 0;
    zy    = 0;
    bound = 64'd5 << FRAC_BITS;
    for (int i = 0; i < int'(lim); i++) begin
      ax  = (zx < 0) ? -zx : zx;
      ay  = (zy < 0) ? -zy : zy;
      tx  = longint'((ax * ax) >> FRAC_BITS) - longint'((ay * ay) >> FRAC_BITS);
      tym = ((2 * ax) * ay) >> FRAC_BITS;
      // cross term truncates toward zero
      ty  = ((zx < 0) != (zy < 0)) ? -longint'(tym) : longint'(tym);
      zx  = tx + cx;
      zy  = ty + cy;
      ax  = (zx < 0) ? -zx : zx;
      ay  = (zy < 0) ? -zy : zy;
      if (ax >= bound || ay >= bound) begin
        r.escaped      = 1'b1;
        r.escape_index = i[ITER_BITS-1:0];
        r.red          = shade(i, 153, 50);
        r.green        = shade(i, 51, 5);
        r.blue         = shade(i, 102, 5);
        return r;
      end
    end
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_out_t want;
    if (!rst_ni) begin
      iter_limit = DEFAULT_LIMIT;
      colour_q.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (colour_q.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, result_i);
          errors_o++;
        end else begin
          want = colour_q.pop_front();
          check_field("escaped", want.escaped, result_i.escaped);
          check_field("escape_index", want.escape_index, result_i.escape_index);
          check_field("red", want.red, result_i.red);
          check_field("green", want.green, result_i.green);
          check_field("blue", want.blue, result_i.blue);
        end
      end
      if (start_i && !busy_i) begin
        colour_q.push_back(escape_predict(pixel_i, iter_limit));
      end
      if (cfg_we_i) begin
        iter_limit = cfg_wdata_i;
      end
      pending_o <= colour_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives points and limit writes into the escape-time pixel block.
`timescale 1ns / 1ps

module tb_top;
  import mbet_pkg::*;

  localparam int QUIET_LIMIT = 100000;
  localparam int NPHASE      = 12;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  pixel_in_t            pixel;
  logic                 done;
  pixel_out_t           result;
  logic                 cfg_we;
  logic [ITER_BITS-1:0] cfg_wdata;
  int                   errors;
  int                   pending;
  int                   burst_left;
  int                   quiet_cycles;

  // -1: limit drawn at random
  int phase_limit [NPHASE] = '{0, 1, 4095, 2, 10, 30, 64, 100, 255, -1, -1, -1};
  int phase_items [NPHASE] = '{15, 25, 10, 25, 50, 60, 60, 40, 30, 40, 40, 40};

  mandelbrot_escape_time_pixel i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pixel_i    (pixel),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  mbet_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .pixel_i    (pixel),
    .done_i     (done),
    .result_i   (result),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic pixel_in_t make_point(int re, int im);
    pixel_in_t p;
    p.point_real = IN_BITS'(re);
    p.point_imag = IN_BITS'(im);
    return p;
  endfunction

  function automatic pixel_in_t rand_point();
    int sel;
    int re;
    int im;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      // around the set
      re = int'($urandom_range(0, 26843546)) - 20971520;
      im = int'($urandom_range(0, 25165824)) - 12582912;
    end else if (sel < 7) begin
      // near the cusp, long orbits
      re = 2097152 + int'($urandom_range(0, 300000));
      im = int'($urandom_range(0, 400000)) - 200000;
    end else if (sel < 9) begin
      re = int'($urandom_range(0, 87241522)) - 43620761;
      im = int'($urandom_range(0, 87241522)) - 43620761;
    end else begin
      re = $urandom();
      im = $urandom();
    end
    return make_point(re, im);
  endfunction

  // returns on the edge of the transfer, start still high
  task automatic send_point(pixel_in_t p);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    pixel <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= ITER_BITS'(v);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int lim;
    rst_ni     = 1'b0;
    start      = 1'b0;
    pixel      = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limit of 10
    send_point(make_point(0, 0));
    send_point(make_point(134217727, 134217727));
    send_point(make_point(-134217728, -134217728));
    send_point(make_point(-134217728, 134217727));
    send_point(make_point(134217727, 0));
    send_point(make_point(0, -134217728));
    send_point(make_point(41943040, 0));     // escape right on 5
    send_point(make_point(41943039, 0));     // just below 5
    send_point(make_point(-41943040, 0));
    send_point(make_point(0, 41943040));
    send_point(make_point(0, -41943039));
    send_point(make_point(-16777216, 0));    // c = -2, bounded
    send_point(make_point(2097152, 0));      // c = 0.25, bounded
    send_point(make_point(2397152, 0));
    send_point(make_point(-8388608, 0));
    send_point(make_point(0, 8388608));
    send_point(make_point(3355443, 5033165));
    send_point(make_point(-5000000, 3000000));
    send_point(make_point(3000000, -5000000));
    send_point(make_point(-6000000, -7000000));

    for (int ph = 0; ph < NPHASE; ph++) begin
      lim = (phase_limit[ph] < 0) ? $urandom_range(3, 80) : phase_limit[ph];
      write_limit(lim);
      if (lim == 4095) begin
        send_point(make_point(2097152, 0));
        send_point(make_point(2117152, 0));
        send_point(make_point(2102152, 0));
      end
      for (int n = 0; n < phase_items[ph]; n++) send_point(rand_point());
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("mandelbrot_escape_time_pixel test passed");
    end else begin
      $display("mandelbrot_escape_time_pixel test failed");
    end
    $finish;
  end

  // watchdog on cycles with no transfer of any kind
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done || cfg_we || !rst_ni) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("mandelbrot_escape_time_pixel test failed");
    $finish;
  end

endmodule
